FILE: hdl/iee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expression;
  } item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } result_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BADCHAR   = 3'd1;
  localparam logic [2:0] ST_DIVZERO   = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_OVERFLOW  = 3'd4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef enum logic [2:0] {
    TK_DIGIT = 3'd0,
    TK_SPACE = 3'd1,
    TK_OP    = 3'd2,
    TK_BAD   = 3'd3,
    TK_END   = 3'd4
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic [1:0] op;
  } token_t;

  function automatic token_t classify(item_t it);
    token_t t;
    t.kind  = TK_BAD;
    t.digit = it.char_code[3:0];
    t.op    = OP_ADD;
    if (it.end_of_expression) begin
      t.kind = TK_END;
    end else if (it.char_code >= 8'h30 && it.char_code <= 8'h39) begin
      t.kind = TK_DIGIT;
    end else begin
      unique case (it.char_code)
        8'h20, 8'h09, 8'h0A: t.kind = TK_SPACE;
        8'h2B: begin t.kind = TK_OP; t.op = OP_ADD; end
        8'h2D: begin t.kind = TK_OP; t.op = OP_SUB; end
        8'h2A: begin t.kind = TK_OP; t.op = OP_MUL; end
        8'h2F: begin t.kind = TK_OP; t.op = OP_DIV; end
        default: t.kind = TK_BAD;
      endcase
    end
    return t;
  endfunction

endpackage

FILE: hdl/iee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_front
// Accepts characters and registers them as classified tokens.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  iee_pkg::item_t item,
  output logic           tok_valid,
  input  logic           tok_full,
  output iee_pkg::token_t tok
);

  logic accept;

  assign item_stall = tok_valid && tok_full;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= accept || (tok_valid && tok_full);
    end
    if (accept) begin
      tok <= iee_pkg::classify(item);
    end
  end

endmodule

FILE: hdl/iee_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_fifo
// Two-entry token queue between the front and the execution engine.
// ----------------------------------------------------------------------------
module iee_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            full,
  input  iee_pkg::token_t push_tok,
  output logic            pop_valid,
  input  logic            pop,
  output iee_pkg::token_t pop_tok
);

  iee_pkg::token_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_tok   = entry[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      entry[wr_ptr] <= push_tok;
    end
  end

endmodule

FILE: hdl/iee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iee_back
// Execution engine: stacks, number accumulator, reduction sequencer and a
// shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
module iee_back #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_valid,
  output logic             tok_pop,
  input  iee_pkg::token_t  tok,
  output logic             result_valid,
  input  logic             result_stall,
  output iee_pkg::result_t result
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int NW = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_OPCHK  = 10'b0000000010,
    S_OPDEC  = 10'b0000000100,
    S_RDB    = 10'b0000001000,
    S_RDA    = 10'b0000010000,
    S_EXEC   = 10'b0000100000,
    S_ITER   = 10'b0001000000,
    S_FINISH = 10'b0010000000,
    S_TOPRD  = 10'b0100000000,
    S_RESULT = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [W-1:0] vmem [STACK_DEPTH];
  logic [1:0]   omem [STACK_DEPTH];
  logic [W-1:0] vrd;
  logic [1:0]   ord;
  logic [AW-1:0] vra, vwa, owa, ora;
  logic [W-1:0] vwd;
  logic [1:0]   owd;
  logic         vwe, owe;

  logic [CW-1:0] vc, vc_next, oc, oc_next;
  logic [W-1:0]  acc, acc_next;
  logic          in_num, in_num_next;
  logic [2:0]    err, err_next;
  logic          pend_end, pend_end_next;
  logic [1:0]    pend_op, pend_op_next;
  logic [1:0]    op_cur, op_cur_next;
  logic [W-1:0]  a, a_next, b, b_next;
  logic [W-1:0]  x, x_next, y, y_next, z, z_next;
  logic [NW-1:0] cnt, cnt_next;
  logic          res_valid_next;
  iee_pkg::result_t res_next;

  logic [CW-1:0] vc_m1, vc_m2, oc_m1;
  logic [W-1:0]  mul_x, mul_y, mul_z;
  logic [W:0]    div_rs, div_trial;
  logic [W-1:0]  div_x, div_y;
  logic [W-1:0]  quo, addsub;
  logic [63:0]   top_wide;
  logic          full_v, full_o;

  assign vc_m1  = vc - CW'(1);
  assign vc_m2  = vc - CW'(2);
  assign oc_m1  = oc - CW'(1);
  assign full_v = (vc >= CW'(STACK_DEPTH));
  assign full_o = (oc >= CW'(STACK_DEPTH));

  // one step of shift-add multiply
  assign mul_x = z[0] ? (x + y) : x;
  assign mul_y = y << 1;
  assign mul_z = z >> 1;

  // one step of restoring divide: y holds remainder, x the quotient
  assign div_rs    = {y, x[W-1]};
  assign div_trial = div_rs - {1'b0, z};
  assign div_y     = div_trial[W] ? div_rs[W-1:0] : div_trial[W-1:0];
  assign div_x     = {x[W-2:0], !div_trial[W]};

  assign quo      = (a[W-1] ^ b[W-1]) ? (W'(0) - div_x) : div_x;
  assign addsub   = (op_cur == iee_pkg::OP_ADD) ? (a + b) : (a - b);
  assign top_wide = 64'(a);

  always_comb begin
    state_next     = state;
    vc_next        = vc;
    oc_next        = oc;
    acc_next       = acc;
    in_num_next    = in_num;
    err_next       = err;
    pend_end_next  = pend_end;
    pend_op_next   = pend_op;
    op_cur_next    = op_cur;
    a_next         = a;
    b_next         = b;
    x_next         = x;
    y_next         = y;
    z_next         = z;
    cnt_next       = cnt;
    res_valid_next = result_valid && result_stall;
    res_next       = result;
    tok_pop        = 1'b0;
    vwe = 1'b0; vwa = vc[AW-1:0]; vwd = acc;
    owe = 1'b0; owa = oc[AW-1:0]; owd = pend_op;
    vra = vc_m1[AW-1:0];
    ora = oc_m1[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (tok_valid) begin
          tok_pop = 1'b1;
          if (tok.kind == iee_pkg::TK_END) begin
            pend_end_next = 1'b1;
            state_next    = S_OPCHK;
            if (err == iee_pkg::ST_OK && in_num) begin
              if (full_v) begin
                err_next = iee_pkg::ST_OVERFLOW;
              end else begin
                vwe     = 1'b1;
                vc_next = vc + CW'(1);
              end
            end
          end else if (err == iee_pkg::ST_OK) begin
            unique case (tok.kind)
              iee_pkg::TK_DIGIT: begin
                acc_next    = (acc << 3) + (acc << 1) + W'(tok.digit);
                in_num_next = 1'b1;
              end
              iee_pkg::TK_SPACE, iee_pkg::TK_OP: begin
                if (in_num) begin
                  if (full_v) begin
                    err_next = iee_pkg::ST_OVERFLOW;
                  end else begin
                    vwe     = 1'b1;
                    vc_next = vc + CW'(1);
                  end
                  acc_next    = '0;
                  in_num_next = 1'b0;
                end
                if (tok.kind == iee_pkg::TK_OP) begin
                  pend_end_next = 1'b0;
                  pend_op_next  = tok.op;
                  state_next    = S_OPCHK;
                end
              end
              default: err_next = iee_pkg::ST_BADCHAR;
            endcase
          end
        end
      end
      S_OPCHK: begin
        if (err != iee_pkg::ST_OK) begin
          state_next = pend_end ? S_FINISH : S_IDLE;
        end else if (oc == '0) begin
          if (pend_end) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_IDLE;
            if (full_o) begin
              err_next = iee_pkg::ST_OVERFLOW;
            end else begin
              owe     = 1'b1;
              oc_next = oc + CW'(1);
            end
          end
        end else begin
          state_next = S_OPDEC;
        end
      end
      S_OPDEC: begin
        op_cur_next = ord;
        if (pend_end || (ord[1] >= pend_op[1])) begin
          if (vc < CW'(2)) begin
            err_next   = iee_pkg::ST_MALFORMED;
            state_next = S_OPCHK;
          end else begin
            state_next = S_RDB;
          end
        end else begin
          state_next = S_IDLE;
          if (full_o) begin
            err_next = iee_pkg::ST_OVERFLOW;
          end else begin
            owe     = 1'b1;
            oc_next = oc + CW'(1);
          end
        end
      end
      S_RDB: begin
        b_next     = vrd;
        vra        = vc_m2[AW-1:0];
        state_next = S_RDA;
      end
      S_RDA: begin
        a_next     = vrd;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cnt_next = '0;
        if (op_cur == iee_pkg::OP_DIV && b == '0) begin
          err_next   = iee_pkg::ST_DIVZERO;
          state_next = S_OPCHK;
        end else if (op_cur == iee_pkg::OP_MUL) begin
          x_next     = '0;
          y_next     = a;
          z_next     = b;
          state_next = S_ITER;
        end else if (op_cur == iee_pkg::OP_DIV) begin
          // magnitudes; the most negative value stays as its own bit pattern
          x_next     = a[W-1] ? (W'(0) - a) : a;
          y_next     = '0;
          z_next     = b[W-1] ? (W'(0) - b) : b;
          state_next = S_ITER;
        end else begin
          vwe        = 1'b1;
          vwa        = vc_m2[AW-1:0];
          vwd        = addsub;
          vc_next    = vc_m1;
          oc_next    = oc_m1;
          state_next = S_OPCHK;
        end
      end
      S_ITER: begin
        cnt_next = cnt + NW'(1);
        if (op_cur == iee_pkg::OP_MUL) begin
          x_next = mul_x;
          y_next = mul_y;
          z_next = mul_z;
        end else begin
          x_next = div_x;
          y_next = div_y;
        end
        if (cnt == NW'(W - 1)) begin
          vwe        = 1'b1;
          vwa        = vc_m2[AW-1:0];
          vwd        = (op_cur == iee_pkg::OP_MUL) ? mul_x : quo;
          vc_next    = vc_m1;
          oc_next    = oc_m1;
          state_next = S_OPCHK;
        end
      end
      S_FINISH: begin
        if (err != iee_pkg::ST_OK) begin
          state_next = S_RESULT;
        end else if (vc == '0) begin
          err_next   = iee_pkg::ST_MALFORMED;
          state_next = S_RESULT;
        end else begin
          state_next = S_TOPRD;
        end
      end
      S_TOPRD: begin
        a_next     = vrd;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!result_valid || !result_stall) begin
          res_valid_next = 1'b1;
          res_next.status = err;
          res_next.value  = (err == iee_pkg::ST_OK) ? signed'(top_wide[31:0]) : '0;
          vc_next     = '0;
          oc_next     = '0;
          acc_next    = '0;
          in_num_next = 1'b0;
          err_next    = iee_pkg::ST_OK;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    if (owe) omem[owa] <= owd;
    vrd <= vmem[vra];
    ord <= omem[ora];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vc           <= '0;
      oc           <= '0;
      acc          <= '0;
      in_num       <= 1'b0;
      err          <= iee_pkg::ST_OK;
      pend_end     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      vc           <= vc_next;
      oc           <= oc_next;
      acc          <= acc_next;
      in_num       <= in_num_next;
      err          <= err_next;
      pend_end     <= pend_end_next;
      result_valid <= res_valid_next;
    end
    pend_op <= pend_op_next;
    op_cur  <= op_cur_next;
    a       <= a_next;
    b       <= b_next;
    x       <= x_next;
    y       <= y_next;
    z       <= z_next;
    cnt     <= cnt_next;
    result  <= res_next;
  end

endmodule

FILE: hdl/infix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an integer infix expression fed one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   item carries one character or, with end_of_expression set, the end
//   marker. Only the end marker produces a request on result: the final
//   value and a status code; value is zero unless status is ok.
//   A character is registered by the front stage and queued (two tokens)
//   for the execution engine, so the front keeps taking requests while the
//   engine works. A token passes through the front register and the queue
//   before the engine takes it. Digits, separators and bad characters are
//   handled in the engine's idle state. An operator goes through OPCHK and,
//   while the operator stack is not empty, OPDEC; each reduction then reads
//   its operands (RDB, RDA) and executes, + and - in EXEC, * and / in the
//   bit-serial multiply/divide unit; stack reads go through registered
//   memory ports. An end marker goes through OPCHK, FINISH and RESULT (via
//   TOPRD when a value is left), with any reductions it triggers before.
//   rst (synchronous) empties stacks, queue and output; stack memories
//   need no clearing pass. While result is stalled the finished request
//   holds, the engine waits at the next end marker, and the queue fills up.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  iee_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output iee_pkg::result_t result
);

  iee_pkg::token_t f_tok, q_tok;
  logic f_valid, q_full, q_valid, q_pop;

  iee_front u_front (
    .clk, .rst, .item_valid, .item_stall, .item,
    .tok_valid (f_valid),
    .tok_full  (q_full),
    .tok       (f_tok)
  );

  iee_fifo u_fifo (
    .clk, .rst,
    .push_valid (f_valid),
    .full       (q_full),
    .push_tok   (f_tok),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_tok    (q_tok)
  );

  iee_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk, .rst,
    .tok_valid (q_valid),
    .tok_pop   (q_pop),
    .tok       (q_tok),
    .result_valid, .result_stall, .result
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives character streams into the infix expression evaluator and checks
// each reported value and status against an in-bench shunting-yard model.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH = 64;
  localparam int LIMIT = 20000;

  class expr_scoreboard;
    logic [31:0] vals[DEPTH];
    logic [1:0]  ops[DEPTH];
    int          nval, nop;
    logic [31:0] acc;
    bit          in_num;
    logic [2:0]  err;
    iee_pkg::result_t pending[$];
    int          fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      nval = 0; nop = 0; acc = '0; in_num = 1'b0; err = iee_pkg::ST_OK;
    endfunction

    function void push(logic [31:0] v);
      if (nval >= DEPTH) begin
        err = iee_pkg::ST_OVERFLOW;
        return;
      end
      vals[nval] = v;
      nval++;
    endfunction

    function void flush_num();
      if (in_num) begin
        push(acc);
        acc = '0;
        in_num = 1'b0;
      end
    endfunction

    function void apply_top();
      logic [31:0] a, b, r, q, ma, mb;
      logic [1:0]  op;
      if (nval < 2) begin
        err = iee_pkg::ST_MALFORMED;
        return;
      end
      b = vals[nval-1];
      a = vals[nval-2];
      op = ops[nop-1];
      if (op == iee_pkg::OP_DIV && b == 0) begin
        err = iee_pkg::ST_DIVZERO;
        return;
      end
      case (op)
        iee_pkg::OP_ADD: r = a + b;
        iee_pkg::OP_SUB: r = a - b;
        iee_pkg::OP_MUL: r = a * b;
        default: begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          r = (a[31] ^ b[31]) ? -q : q;
        end
      endcase
      nop--;
      nval -= 2;
      push(r);
    endfunction

    function void note_request(iee_pkg::item_t it);
      iee_pkg::result_t res;
      logic [7:0] c;
      logic [1:0] code;
      c = it.char_code;
      if (it.end_of_expression) begin
        res.value = '0;
        if (err == iee_pkg::ST_OK) flush_num();
        while (err == iee_pkg::ST_OK && nop > 0) apply_top();
        if (err == iee_pkg::ST_OK && nval == 0) err = iee_pkg::ST_MALFORMED;
        if (err == iee_pkg::ST_OK) res.value = vals[nval-1];
        res.status = err;
        pending.push_back(res);
        clear();
        return;
      end
      if (err != iee_pkg::ST_OK) return;
      if (c >= "0" && c <= "9") begin
        acc = acc * 10 + 32'(c - 8'h30);
        in_num = 1'b1;
        return;
      end
      if (c == " " || c == 8'h09 || c == 8'h0A) begin
        flush_num();
        return;
      end
      case (c)
        "+": code = iee_pkg::OP_ADD;
        "-": code = iee_pkg::OP_SUB;
        "*": code = iee_pkg::OP_MUL;
        "/": code = iee_pkg::OP_DIV;
        default: begin
          err = iee_pkg::ST_BADCHAR;
          return;
        end
      endcase
      flush_num();
      while (err == iee_pkg::ST_OK && nop > 0 && ops[nop-1][1] >= code[1]) apply_top();
      if (err != iee_pkg::ST_OK) return;
      if (nop >= DEPTH) begin
        err = iee_pkg::ST_OVERFLOW;
        return;
      end
      ops[nop] = code;
      nop++;
    endfunction

    function void check_result(iee_pkg::result_t got);
      iee_pkg::result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result value=%0d status=%0d", got.value, got.status);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        fails++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic    clk, rst;
  logic    item_valid, item_stall, result_valid, result_stall;
  iee_pkg::item_t   item;
  iee_pkg::result_t result;
  expr_scoreboard sb;
  bit      hold_long;
  int      idle_cycles;

  infix_expression_evaluator uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int k, mode;
    result_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        result_stall <= 1;
        for (k = 0; k < 3000; k++) @(posedge clk);
        result_stall <= 0;
        hold_long = 0;
      end else begin
        mode = $urandom_range(0, 3);
        if (mode == 0) result_stall <= 0;
        else result_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  iee_pkg::item_t stream[$];
  int    burst_left;

  // one request per call; holds valid across back-to-back items
  task automatic send(iee_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    item_valid <= 1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_request(it);
    burst_left--;
  endtask

  task automatic add_ch(logic [7:0] c);
    iee_pkg::item_t it;
    it.char_code = c;
    it.end_of_expression = 1'b0;
    stream.push_back(it);
  endtask

  task automatic add_end();
    iee_pkg::item_t it;
    it.char_code = 8'($urandom);
    it.end_of_expression = 1'b1;
    stream.push_back(it);
  endtask

  task automatic add_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_ch(s[i]);
    add_end();
  endtask

  task automatic add_number();
    int n, i;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    for (i = 0; i < n; i++) add_ch(8'(8'h30 + $urandom_range(0, 9)));
  endtask

  task automatic add_op();
    case ($urandom_range(0, 3))
      0: add_ch("+");
      1: add_ch("-");
      2: add_ch("*");
      default: add_ch("/");
    endcase
  endtask

  task automatic add_sep();
    case ($urandom_range(0, 5))
      0: add_ch(" ");
      1: add_ch(8'h09);
      2: add_ch(8'h0A);
      default: ;
    endcase
  endtask

  task automatic add_random_expr();
    int n, i, kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) add_ch(8'($urandom));
    end else begin
      n = $urandom_range(0, 5);
      add_sep();
      add_number();
      for (i = 0; i < n; i++) begin
        add_sep(); add_op(); add_sep();
        if (kind == 1 && $urandom_range(0, 2) == 0) add_op();
        else add_number();
      end
      if (kind == 2) add_op();
      add_sep();
    end
    add_end();
  endtask

  task automatic drain();
    while (stream.size() > 0) send(stream.pop_front());
    item_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    int i;
    iee_pkg::item_t it;
    sb = new();
    hold_long = 0;
    burst_left = 0;
    rst = 1;
    item_valid = 0;
    item = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_str("1+2*3");
    add_str("7-10/3");
    add_str("-7");
    add_str("");
    add_str("5/0");
    add_str("2147483648*-1/-1");
    add_str("0-2147483648/1");
    add_str("1 2");
    add_str("99999999999");
    add_str("3\t*\n4 - 2");
    add_str("12a+3");
    it.char_code = 8'h00; it.end_of_expression = 1'b0; stream.push_back(it);
    add_end();
    it.char_code = 8'hFF; stream.push_back(it);
    add_end();
    add_str("8/-3");
    for (i = 0; i < 65; i++) begin add_ch("1"); add_ch(" "); end
    add_end();
    for (i = 0; i < 20; i++) begin add_ch("1"); add_ch("+"); end
    add_ch("1");
    add_end();
    drain();

    // fill the block while results are held back
    hold_long = 1;
    for (i = 0; i < 6; i++) add_random_expr();
    drain();

    while (stream.size() < 50) add_random_expr();
    drain();

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: infix_expression_evaluator.f
hdl/iee_pkg.sv
hdl/iee_front.sv
hdl/iee_fifo.sv
hdl/iee_back.sv
hdl/infix_expression_evaluator.sv
sim/tb.sv
